@@ design/c6502_pkg.sv @@
// Shared types and constants of the 6502 execute unit.
package c6502_pkg;

   typedef enum logic [5:0] {
      K_NOP, K_LDA, K_LDX, K_LDY, K_STA, K_STX, K_STY,
      K_TAX, K_TAY, K_TXA, K_TYA, K_TSX, K_TXS,
      K_ADC, K_SBC, K_AND, K_ORA, K_EOR, K_CMP, K_CPX, K_CPY, K_BIT,
      K_ASLA, K_LSRA, K_ROLA, K_RORA, K_ASLM, K_LSRM, K_ROLM, K_RORM,
      K_INC, K_DEC, K_INX, K_INY, K_DEX, K_DEY,
      K_CLC, K_SEC, K_CLI, K_SEI, K_CLV, K_CLD, K_SED,
      K_BRANCH
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  cond_sel;
      logic        cond_val;
      logic [7:0]  operand;
      logic [15:0] next_pc;
      logic [15:0] target;
   } decoded_type;

   localparam logic [7:0] FLAGS_RESET = 8'h24;
   localparam logic [7:0] SP_RESET    = 8'hFD;
   localparam int FN = 7;
   localparam int FV = 6;
   localparam int FD = 3;
   localparam int FI = 2;
   localparam int FZ = 1;
   localparam int FC = 0;

   function automatic kind_type decode_op(input logic [7:0] op);
      kind_type k;
      k = K_NOP;
      case (op)
         8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: k = K_LDA;
         8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: k = K_LDX;
         8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: k = K_LDY;
         8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91: k = K_STA;
         8'h86, 8'h96, 8'h8E: k = K_STX;
         8'h84, 8'h94, 8'h8C: k = K_STY;
         8'hAA: k = K_TAX;
         8'hA8: k = K_TAY;
         8'h8A: k = K_TXA;
         8'h98: k = K_TYA;
         8'hBA: k = K_TSX;
         8'h9A: k = K_TXS;
         8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: k = K_ADC;
         8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1, 8'hEB: k = K_SBC;
         8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: k = K_AND;
         8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: k = K_ORA;
         8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: k = K_EOR;
         8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: k = K_CMP;
         8'hE0, 8'hE4, 8'hEC: k = K_CPX;
         8'hC0, 8'hC4, 8'hCC: k = K_CPY;
         8'h24, 8'h2C: k = K_BIT;
         8'h0A: k = K_ASLA;
         8'h4A: k = K_LSRA;
         8'h2A: k = K_ROLA;
         8'h6A: k = K_RORA;
         8'h06, 8'h16, 8'h0E, 8'h1E: k = K_ASLM;
         8'h46, 8'h56, 8'h4E, 8'h5E: k = K_LSRM;
         8'h26, 8'h36, 8'h2E, 8'h3E: k = K_ROLM;
         8'h66, 8'h76, 8'h6E, 8'h7E: k = K_RORM;
         8'hE6, 8'hF6, 8'hEE, 8'hFE: k = K_INC;
         8'hC6, 8'hD6, 8'hCE, 8'hDE: k = K_DEC;
         8'hE8: k = K_INX;
         8'hC8: k = K_INY;
         8'hCA: k = K_DEX;
         8'h88: k = K_DEY;
         8'h18: k = K_CLC;
         8'h38: k = K_SEC;
         8'h58: k = K_CLI;
         8'h78: k = K_SEI;
         8'hB8: k = K_CLV;
         8'hD8: k = K_CLD;
         8'hF8: k = K_SED;
         8'h90, 8'hB0, 8'hF0, 8'hD0, 8'h30, 8'h10, 8'h50, 8'h70: k = K_BRANCH;
         default: k = K_NOP;
      endcase
      return k;
   endfunction

endpackage

@@ design/cpu6502_execute_unit.sv @@
// Top level of the 6502 execute unit: decode, queue and execute.
// Usage:
//  - Request channel (req_*): opcode, operand byte, next_pc; one
//    instruction per request, accepted when req_valid and req_ready.
//  - Response channel (rsp_*): one response per request, in order,
//    with store data, branch outcome and A, X, Y, P after the step.
//  - Path: an accepted request is written into the two-entry queue,
//    executes from the queue head, and its response is registered
//    in the response register before rsp_valid rises.
//  - Throughput: one request per cycle while rsp_ready is high, set
//    by the execute stage that updates A, X, Y, S and P.
//  - Reset: A, X, Y clear, S becomes 0xFD, P becomes 0x24; queue and
//    response register empty.
//  - Stall: while rsp_ready is low the response holds, execution
//    stops and the queue absorbs up to two more requests before
//    req_ready drops.
module cpu6502_execute_unit import c6502_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_operand,
   input  logic [15:0] req_next_pc,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_mem_write,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_branch_taken,
   output logic [15:0] rsp_branch_target,
   output logic [1:0]  rsp_extra_cycles,
   output logic [7:0]  rsp_flags_out,
   output logic [7:0]  rsp_acc_out,
   output logic [7:0]  rsp_index_x_out,
   output logic [7:0]  rsp_index_y_out
);
   decoded_type dec_in, dec_q;
   logic        q_valid, q_ready;

   // Classify the request before it enters the queue.
   c6502_decode u_dec (
      .opcode(req_opcode), .operand(req_operand), .next_pc(req_next_pc), .dec(dec_in)
   );

   c6502_queue u_q (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_data(dec_in),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(dec_q)
   );

   c6502_exec u_ex (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .dec(dec_q),
      .rsp_valid, .rsp_ready, .rsp_mem_write, .rsp_write_data,
      .rsp_branch_taken, .rsp_branch_target, .rsp_extra_cycles,
      .rsp_flags_out, .rsp_acc_out, .rsp_index_x_out, .rsp_index_y_out
   );
endmodule

@@ design/c6502_decode.sv @@
// Front end: classify the opcode and form the branch target.
module c6502_decode import c6502_pkg::*; (
   input  logic [7:0]  opcode,
   input  logic [7:0]  operand,
   input  logic [15:0] next_pc,
   output decoded_type dec
);
   always_comb begin
      dec.kind     = decode_op(opcode);
      dec.cond_sel = opcode[7:6];
      dec.cond_val = opcode[5];
      dec.operand  = operand;
      dec.next_pc  = next_pc;
      dec.target   = next_pc + {{8{operand[7]}}, operand};
   end
endmodule

@@ design/c6502_queue.sv @@
// Two-entry queue between the decode front end and the execute back end.
module c6502_queue import c6502_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  decoded_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output decoded_type out_data
);
   decoded_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready) else $error("queue full but ready");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count slip");
   a_empty_idle: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !out_valid) else $error("empty queue valid");
endmodule

@@ design/c6502_exec.sv @@
// Back end: architectural registers, execution and the output register.
module c6502_exec import c6502_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  decoded_type dec,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_mem_write,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_branch_taken,
   output logic [15:0] rsp_branch_target,
   output logic [1:0]  rsp_extra_cycles,
   output logic [7:0]  rsp_flags_out,
   output logic [7:0]  rsp_acc_out,
   output logic [7:0]  rsp_index_x_out,
   output logic [7:0]  rsp_index_y_out
);
   logic [7:0] a_ff, x_ff, y_ff, s_ff, p_ff;
   logic [7:0] a_in, x_in, y_in, s_in, p_in;
   logic       wr_in, tk_in;
   logic [7:0] wd_in;
   logic [15:0] tg_in;
   logic [1:0] ex_in;
   logic       vld_ff;
   logic       fire;
   logic [7:0] v, sh_src, sh_res, alu_b, cmp_reg;
   logic [8:0] sum, diff;
   logic       cbit;

   assign in_ready = !vld_ff || rsp_ready;
   assign fire     = in_valid && in_ready;
   assign v        = dec.operand;

   always_comb begin
      a_in = a_ff; x_in = x_ff; y_in = y_ff; s_in = s_ff; p_in = p_ff;
      wr_in = 1'b0; wd_in = 8'd0; tk_in = 1'b0; tg_in = 16'd0; ex_in = 2'd0;
      alu_b = (dec.kind == K_SBC) ? ~v : v;
      sum = {1'b0, a_ff} + {1'b0, alu_b} + {8'd0, p_ff[FC]};
      case (dec.kind)
         K_CPX:   cmp_reg = x_ff;
         K_CPY:   cmp_reg = y_ff;
         default: cmp_reg = a_ff;
      endcase
      diff = {1'b0, cmp_reg} - {1'b0, v};
      case (dec.kind)
         K_ASLA, K_LSRA, K_ROLA, K_RORA: sh_src = a_ff;
         default:                        sh_src = v;
      endcase
      case (dec.kind)
         K_ASLA, K_ASLM: sh_res = {sh_src[6:0], 1'b0};
         K_ROLA, K_ROLM: sh_res = {sh_src[6:0], p_ff[FC]};
         K_LSRA, K_LSRM: sh_res = {1'b0, sh_src[7:1]};
         default:        sh_res = {p_ff[FC], sh_src[7:1]};
      endcase
      case (dec.cond_sel)
         2'd0:    cbit = p_ff[FN];
         2'd1:    cbit = p_ff[FV];
         2'd2:    cbit = p_ff[FC];
         default: cbit = p_ff[FZ];
      endcase
      case (dec.kind)
         K_LDA: a_in = v;
         K_LDX: x_in = v;
         K_LDY: y_in = v;
         K_STA: begin wr_in = 1'b1; wd_in = a_ff; end
         K_STX: begin wr_in = 1'b1; wd_in = x_ff; end
         K_STY: begin wr_in = 1'b1; wd_in = y_ff; end
         K_TAX: x_in = a_ff;
         K_TAY: y_in = a_ff;
         K_TXA: a_in = x_ff;
         K_TYA: a_in = y_ff;
         K_TSX: x_in = s_ff;
         K_TXS: s_in = x_ff;
         K_ADC, K_SBC: begin
            a_in = sum[7:0];
            p_in[FC] = sum[8];
            p_in[FV] = ~(a_ff[7] ^ alu_b[7]) & (a_ff[7] ^ sum[7]);
         end
         K_AND: a_in = a_ff & v;
         K_ORA: a_in = a_ff | v;
         K_EOR: a_in = a_ff ^ v;
         K_CMP, K_CPX, K_CPY: p_in[FC] = !diff[8];
         K_BIT: begin
            p_in[FZ] = ((a_ff & v) == 8'd0);
            p_in[FN] = v[7];
            p_in[FV] = v[6];
         end
         K_ASLA, K_ROLA: begin a_in = sh_res; p_in[FC] = sh_src[7]; end
         K_LSRA, K_RORA: begin a_in = sh_res; p_in[FC] = sh_src[0]; end
         K_ASLM, K_ROLM: begin wr_in = 1'b1; wd_in = sh_res; p_in[FC] = sh_src[7]; end
         K_LSRM, K_RORM: begin wr_in = 1'b1; wd_in = sh_res; p_in[FC] = sh_src[0]; end
         K_INC: begin wr_in = 1'b1; wd_in = v + 8'd1; end
         K_DEC: begin wr_in = 1'b1; wd_in = v - 8'd1; end
         K_INX: x_in = x_ff + 8'd1;
         K_INY: y_in = y_ff + 8'd1;
         K_DEX: x_in = x_ff - 8'd1;
         K_DEY: y_in = y_ff - 8'd1;
         K_CLC: p_in[FC] = 1'b0;
         K_SEC: p_in[FC] = 1'b1;
         K_CLI: p_in[FI] = 1'b0;
         K_SEI: p_in[FI] = 1'b1;
         K_CLV: p_in[FV] = 1'b0;
         K_CLD: p_in[FD] = 1'b0;
         K_SED: p_in[FD] = 1'b1;
         K_BRANCH: begin
            tg_in = dec.target;
            if (cbit == dec.cond_val) begin
               tk_in = 1'b1;
               ex_in = (dec.target[15:8] != dec.next_pc[15:8]) ? 2'd2 : 2'd1;
            end
         end
         default: ;
      endcase
      // Set N and Z from the value each group produces.
      case (dec.kind)
         K_LDA, K_TXA, K_TYA, K_ADC, K_SBC, K_AND, K_ORA, K_EOR,
         K_ASLA, K_LSRA, K_ROLA, K_RORA: begin
            p_in[FZ] = (a_in == 8'd0); p_in[FN] = a_in[7];
         end
         K_LDX, K_TAX, K_TSX, K_INX, K_DEX: begin
            p_in[FZ] = (x_in == 8'd0); p_in[FN] = x_in[7];
         end
         K_LDY, K_TAY, K_INY, K_DEY: begin
            p_in[FZ] = (y_in == 8'd0); p_in[FN] = y_in[7];
         end
         K_ASLM, K_LSRM, K_ROLM, K_RORM, K_INC, K_DEC: begin
            p_in[FZ] = (wd_in == 8'd0); p_in[FN] = wd_in[7];
         end
         K_CMP, K_CPX, K_CPY: begin
            p_in[FZ] = (diff[7:0] == 8'd0); p_in[FN] = diff[7];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= 8'd0; x_ff <= 8'd0; y_ff <= 8'd0;
         s_ff <= SP_RESET; p_ff <= FLAGS_RESET;
         vld_ff <= 1'b0;
      end else begin
         if (fire) begin
            a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; s_ff <= s_in; p_ff <= p_in;
            rsp_mem_write     <= wr_in;
            rsp_write_data    <= wd_in;
            rsp_branch_taken  <= tk_in;
            rsp_branch_target <= tg_in;
            rsp_extra_cycles  <= ex_in;
            rsp_flags_out     <= p_in;
            rsp_acc_out       <= a_in;
            rsp_index_x_out   <= x_in;
            rsp_index_y_out   <= y_in;
            vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = vld_ff;

   a_ub_fixed: assert property (@(posedge clock) disable iff (reset)
      p_ff[5:4] == 2'b10) else $error("U or B changed");
   a_regs_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(a_ff) && $stable(p_ff)) else $error("state moved");
   a_extra_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_branch_taken |-> rsp_extra_cycles == 2'd0)
      else $error("extra cycles without branch");
endmodule
